// ===== rtl/core/tqwpa_pkg.sv =====
// Package for the two-queue weighted priority arbiter.
// Opcode and status codes, field widths and the controller/datapath interface.
// No dependencies.
package tqwpa_pkg;

  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int SERVICE_W = 8;
  localparam int USER_W    = 16;
  localparam int ENTRY_W   = SERVICE_W + USER_W;
  localparam int LIMIT_W   = 8;

  localparam logic [LIMIT_W-1:0] BURST_LIMIT_RESET = 8'd10;

  localparam logic [OP_W-1:0] OP_PUSH_HIGH = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_LOW  = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVE     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SERVED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic push;    // push request accepted this cycle
    logic serve;   // serve request accepted this cycle
    logic finish;  // read data is ready, load the serve result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or drained this cycle
  } dp_stat_t;

endpackage

// ===== rtl/core/tqwpa_ctrl.sv =====
// Controller for the two-queue arbiter: accepts requests, sequences serve reads.
// Depends on tqwpa_pkg.
module tqwpa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tqwpa_pkg::OP_W-1:0]    in_op,
  input  tqwpa_pkg::dp_stat_t           stat,
  output tqwpa_pkg::ctrl_cmd_t          cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r;
  logic   accept;
  logic   is_serve;

  assign in_tready = (state_r == S_IDLE) && stat.out_free;
  assign accept    = in_tvalid && in_tready;
  // Opcode three decodes as a serve
  assign is_serve  = (in_op != tqwpa_pkg::OP_PUSH_HIGH) &&
                     (in_op != tqwpa_pkg::OP_PUSH_LOW);

  assign cmd.push   = accept && !is_serve;
  assign cmd.serve  = accept && is_serve;
  assign cmd.finish = (state_r == S_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept && is_serve) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tqwpa_dp.sv =====
// Datapath for the two-queue arbiter: both request FIFOs, grant counter,
// burst limit register and the output register. Depends on tqwpa_pkg.
module tqwpa_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tqwpa_pkg::ctrl_cmd_t                 cmd,
  output tqwpa_pkg::dp_stat_t                  stat,
  input  logic [tqwpa_pkg::OP_W-1:0]           in_op,
  input  logic [tqwpa_pkg::SERVICE_W-1:0]      in_service,
  input  logic [tqwpa_pkg::USER_W-1:0]         in_user,
  input  logic                                 cfg_we,
  input  logic [tqwpa_pkg::LIMIT_W-1:0]        cfg_limit,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tqwpa_pkg::ENTRY_W-1:0]        out_tdata,
  output logic [tqwpa_pkg::STATUS_W:0]         out_tuser
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
  localparam int EW = tqwpa_pkg::ENTRY_W;
  localparam int LW = tqwpa_pkg::LIMIT_W;

  logic [EW-1:0] hq_mem [QUEUE_DEPTH];
  logic [EW-1:0] lq_mem [QUEUE_DEPTH];

  logic [PW-1:0] hq_rp_r, hq_wp_r, lq_rp_r, lq_wp_r;
  logic [FW-1:0] hq_fill_r, lq_fill_r, hq_fill_nxt, lq_fill_nxt;
  logic [LW-1:0] grant_r, grant_nxt, limit_r;
  logic [EW-1:0] hq_rdata_r, lq_rdata_r;
  logic          srv_high_r, srv_got_r;

  logic          out_valid_r;
  logic [EW-1:0] out_data_r;
  logic [tqwpa_pkg::STATUS_W-1:0] out_status_r;
  logic          out_high_r;

  logic [EW-1:0] entry;
  logic          push_h, push_l, push_full;
  logic          h_ne, l_ne, limit_hit;
  logic          take_h, take_l;
  logic          pop_h, pop_l;
  logic [EW-1:0] srv_data;

  assign entry = {in_service, in_user};
  assign h_ne  = (hq_fill_r != '0);
  assign l_ne  = (lq_fill_r != '0);
  assign limit_hit = (grant_r >= limit_r);

  assign push_h = cmd.push && (in_op == tqwpa_pkg::OP_PUSH_HIGH) && (hq_fill_r != FILL_MAX);
  assign push_l = cmd.push && (in_op == tqwpa_pkg::OP_PUSH_LOW)  && (lq_fill_r != FILL_MAX);
  assign push_full = !push_h && !push_l;

  // High wins below the limit; past the limit it still wins if low is empty
  assign take_h = h_ne && (!limit_hit || !l_ne);
  assign take_l = l_ne && !(h_ne && !limit_hit);
  assign pop_h  = cmd.serve && take_h;
  assign pop_l  = cmd.serve && take_l;

  always_comb begin
    grant_nxt = grant_r;
    if (cmd.serve) begin
      if (h_ne && !limit_hit) begin
        grant_nxt = grant_r + LW'(1);
      end else if (l_ne) begin
        if (limit_hit) begin
          grant_nxt = '0;
        end
      end else if (h_ne) begin
        grant_nxt = LW'(1);
      end
    end
  end

  always_comb begin
    hq_fill_nxt = hq_fill_r;
    lq_fill_nxt = lq_fill_r;
    if (push_h) hq_fill_nxt = hq_fill_r + FW'(1);
    if (pop_h)  hq_fill_nxt = hq_fill_r - FW'(1);
    if (push_l) lq_fill_nxt = lq_fill_r + FW'(1);
    if (pop_l)  lq_fill_nxt = lq_fill_r - FW'(1);
  end

  // Queue stores
  always_ff @(posedge clk) begin
    if (push_h) hq_mem[hq_wp_r] <= entry;
    if (pop_h)  hq_rdata_r <= hq_mem[hq_rp_r];
  end

  always_ff @(posedge clk) begin
    if (push_l) lq_mem[lq_wp_r] <= entry;
    if (pop_l)  lq_rdata_r <= lq_mem[lq_rp_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.serve) begin
      srv_high_r <= take_h;
      srv_got_r  <= take_h || take_l;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hq_rp_r   <= '0;
      hq_wp_r   <= '0;
      lq_rp_r   <= '0;
      lq_wp_r   <= '0;
      hq_fill_r <= '0;
      lq_fill_r <= '0;
      grant_r   <= '0;
      limit_r   <= tqwpa_pkg::BURST_LIMIT_RESET;
    end else begin
      if (push_h) hq_wp_r <= (hq_wp_r == PTR_LAST) ? '0 : hq_wp_r + PW'(1);
      if (pop_h)  hq_rp_r <= (hq_rp_r == PTR_LAST) ? '0 : hq_rp_r + PW'(1);
      if (push_l) lq_wp_r <= (lq_wp_r == PTR_LAST) ? '0 : lq_wp_r + PW'(1);
      if (pop_l)  lq_rp_r <= (lq_rp_r == PTR_LAST) ? '0 : lq_rp_r + PW'(1);
      hq_fill_r <= hq_fill_nxt;
      lq_fill_r <= lq_fill_nxt;
      grant_r   <= grant_nxt;
      if (cfg_we) limit_r <= cfg_limit;
    end
  end

  assign srv_data = !srv_got_r ? '0 : (srv_high_r ? hq_rdata_r : lq_rdata_r);

  // Output register: push results load at accept, serve results in the cycle after accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_status_r <= push_full ? tqwpa_pkg::ST_PUSH_FULL : tqwpa_pkg::ST_PUSH_OK;
      out_high_r   <= 1'b0;
      out_data_r   <= '0;
    end else if (cmd.finish) begin
      out_status_r <= srv_got_r ? tqwpa_pkg::ST_SERVED : tqwpa_pkg::ST_EMPTY;
      out_high_r   <= srv_got_r && srv_high_r;
      out_data_r   <= srv_data;
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  // Service in the low byte, user above it
  assign out_tdata     = {out_data_r[tqwpa_pkg::USER_W-1:0],
                          out_data_r[EW-1:tqwpa_pkg::USER_W]};
  assign out_tuser     = {out_high_r, out_status_r};

endmodule

// ===== rtl/core/two_queue_weighted_priority_arbiter.sv =====
// Top level of the two-queue weighted priority arbiter.
// Instantiates tqwpa_ctrl and tqwpa_dp; depends on tqwpa_pkg.
//
//  channel | ports                           | contents
//  --------+---------------------------------+--------------------------------------
//  in      | in_tvalid/in_tready/tdata/tuser | push or serve request
//  out     | out_tvalid/out_tready/tdata/tuser| status, source flag, served entry
//  cfg     | cfg_valid/cfg_ready/cfg_data    | high burst limit (always ready)
//
// A push request's result is loaded at the accept edge. For a serve request
// the queue memory read is registered before the result is loaded. A new
// request is accepted only when no serve read is pending and the output
// register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous) empties both queues, clears the grant count
// and sets the burst limit to 10; queue contents are not cleared.
module two_queue_weighted_priority_arbiter #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] service_in, [23:8] user_in
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] service_out, [23:8] user_out
  output logic [2:0]  out_tuser,  // [1:0] status, [2] from_high
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  tqwpa_pkg::ctrl_cmd_t cmd;
  tqwpa_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  tqwpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  tqwpa_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tuser),
    .in_service (in_tdata[7:0]),
    .in_user    (in_tdata[23:8]),
    .cfg_we     (cfg_valid),
    .cfg_limit  (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_accept_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("request accepted while a result is still held");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_tvalid)
    else $error("push request gave no result");

  a_serve_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.serve |=> (cmd.finish && !in_tready) ##1 out_tvalid)
    else $error("serve request did not complete in two cycles");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.serve) && !(cmd.finish && (cmd.push || cmd.serve)))
    else $error("overlapping datapath commands");
`endif

endmodule
